// File: rtl/imu_fp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imu_fp_pkg;

    localparam int unsigned GOOD_SHORT_FRAME = 5;
    localparam int unsigned GOOD_FRAME_EXTRA = 8;

    localparam logic [7:0] START_FLAG_RESET   = 8'd252;
    localparam logic [7:0] END_FLAG_RESET     = 8'd253;
    localparam logic [7:0] CONNECT_FLAG_RESET = 8'd254;

    typedef enum logic [1:0] {
        CFG_START_FLAG   = 2'd0,
        CFG_END_FLAG     = 2'd1,
        CFG_CONNECT_FLAG = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_PAYLOAD = 2'd1,
        ST_DONE    = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef enum logic [8:0] {
        PH_START  = 9'b0_0000_0001,
        PH_CMD    = 9'b0_0000_0010,
        PH_LEN    = 9'b0_0000_0100,
        PH_SERIAL = 9'b0_0000_1000,
        PH_HCHK   = 9'b0_0001_0000,
        PH_PCHK_H = 9'b0_0010_0000,
        PH_PCHK_L = 9'b0_0100_0000,
        PH_DATA   = 9'b0_1000_0000,
        PH_END    = 9'b1_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] start_flag;
        logic [7:0] end_flag;
        logic [7:0] connect_flag;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_type;
        logic [7:0]  serial_number;
        logic [7:0]  payload_length;
        logic [7:0]  header_check;
        logic [15:0] payload_check;
        logic [31:0] lost_frames;
        logic [31:0] good_bytes;
        logic [31:0] total_bytes;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/imu_fp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    output imu_fp_pkg::t_cfg       o_cfg
);
    import imu_fp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_flag   <= START_FLAG_RESET;
            r_cfg.end_flag     <= END_FLAG_RESET;
            r_cfg.connect_flag <= CONNECT_FLAG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_FLAG:   r_cfg.start_flag   <= i_cfg_data;
                CFG_END_FLAG:     r_cfg.end_flag     <= i_cfg_data;
                CFG_CONNECT_FLAG: r_cfg.connect_flag <= i_cfg_data;
                CFG_UNUSED: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/imu_fp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_rx_byte,
    input  wire imu_fp_pkg::t_cfg  i_cfg,
    output imu_fp_pkg::t_result    o_result
);
    import imu_fp_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_remaining,    n_remaining;
    logic [7:0]  r_count,        n_count;
    logic [7:0]  r_type,         n_type;
    logic [7:0]  r_serial,       n_serial;
    logic [7:0]  r_length,       n_length;
    logic [7:0]  r_hchk,         n_hchk;
    logic [15:0] r_pchk,         n_pchk;
    logic [31:0] r_lost,         n_lost;
    logic [31:0] r_good,         n_good;
    logic [31:0] r_total,        n_total;

    t_status     status;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;
    logic        err;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_count     = r_count;
        n_type      = r_type;
        n_serial    = r_serial;
        n_length    = r_length;
        n_hchk      = r_hchk;
        n_pchk      = r_pchk;
        n_lost      = r_lost;
        n_good      = r_good;
        n_total     = r_total + 32'd1;
        status      = ST_BUSY;
        pbyte       = 8'd0;
        pidx        = 8'd0;
        err         = 1'b0;

        unique case (r_phase)
            PH_START: begin
                n_remaining = 8'd0;
                n_count     = 8'd0;
                n_type      = 8'd0;
                priority if (i_rx_byte == i_cfg.connect_flag) begin
                    n_phase = PH_START;
                end else if (i_rx_byte != i_cfg.start_flag) begin
                    err = 1'b1;
                end else begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_type  = i_rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_length    = i_rx_byte;
                n_remaining = i_rx_byte;
                n_phase     = PH_SERIAL;
            end
            PH_SERIAL: begin
                n_serial = i_rx_byte;
                n_phase  = PH_HCHK;
            end
            PH_HCHK: begin
                n_hchk = i_rx_byte;
                if (r_remaining == 8'd0) begin
                    n_phase = PH_START;
                    n_good  = r_good + 32'(GOOD_SHORT_FRAME);
                    status  = ST_DONE;
                end else begin
                    n_phase = PH_PCHK_H;
                end
            end
            PH_PCHK_H: begin
                n_pchk  = {8'd0, i_rx_byte};
                n_phase = PH_PCHK_L;
            end
            PH_PCHK_L: begin
                n_pchk  = {r_pchk[7:0], i_rx_byte};
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (r_remaining == 8'd0) begin
                    err = 1'b1;
                end else begin
                    pbyte       = i_rx_byte;
                    pidx        = r_count;
                    n_count     = r_count + 8'd1;
                    n_remaining = r_remaining - 8'd1;
                    if (r_remaining == 8'd1) begin
                        n_phase = PH_END;
                    end
                    status = ST_PAYLOAD;
                end
            end
            PH_END: begin
                if (i_rx_byte != i_cfg.end_flag) begin
                    err = 1'b1;
                end else begin
                    n_phase = PH_START;
                    n_good  = r_good + {24'd0, r_count} + 32'(GOOD_FRAME_EXTRA);
                    status  = ST_DONE;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (err) begin
            n_lost  = r_lost + 32'd1;
            n_phase = PH_START;
            status  = ST_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_remaining <= 8'd0;
            r_count     <= 8'd0;
            r_type      <= 8'd0;
            r_serial    <= 8'd0;
            r_length    <= 8'd0;
            r_hchk      <= 8'd0;
            r_pchk      <= 16'd0;
            r_lost      <= 32'd0;
            r_good      <= 32'd0;
            r_total     <= 32'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_type      <= n_type;
            r_serial    <= n_serial;
            r_length    <= n_length;
            r_hchk      <= n_hchk;
            r_pchk      <= n_pchk;
            r_lost      <= n_lost;
            r_good      <= n_good;
            r_total     <= n_total;
        end
    end

    always_comb begin
        o_result.status         = status;
        o_result.payload_byte   = pbyte;
        o_result.payload_index  = pidx;
        o_result.frame_type     = n_type;
        o_result.serial_number  = n_serial;
        o_result.payload_length = n_length;
        o_result.header_check   = n_hchk;
        o_result.payload_check  = n_pchk;
        o_result.lost_frames    = n_lost;
        o_result.good_bytes     = n_good;
        o_result.total_bytes    = n_total;
    end

endmodule

`default_nettype wire

// File: rtl/imu_fp_outreg.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_outreg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire imu_fp_pkg::t_result  i_result,
    input  wire logic                 i_out_stall,
    output logic                      o_full,
    output imu_fp_pkg::t_result       o_result
);
    import imu_fp_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_full   = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/imu_serial_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Valid           Stall           Payload
// input     i_in_valid      o_in_stall      i_rx_byte
// output    o_out_valid     i_out_stall     o_status .. o_total_bytes
// config    i_cfg_we        (none)          i_cfg_index, i_cfg_data
//
// One byte per cycle while the input is not stalled; each accepted request yields one result in the next cycle.
// The frame state and counters update in a single pass, the result lands in one output register.
// Input stalls only while the output register holds a result that is itself stalled.
// Synchronous active-low reset returns to the start phase with counters at zero.

module imu_serial_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_payload_byte,
    output logic [7:0]       o_payload_index,
    output logic [7:0]       o_frame_type,
    output logic [7:0]       o_serial_number,
    output logic [7:0]       o_payload_length,
    output logic [7:0]       o_header_check,
    output logic [15:0]      o_payload_check,
    output logic [31:0]      o_lost_frames,
    output logic [31:0]      o_good_bytes,
    output logic [31:0]      o_total_bytes
);
    import imu_fp_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    out_full;
    logic    accept;

    assign o_in_stall = out_full && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    imu_fp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    imu_fp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    imu_fp_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_full      (out_full),
        .o_result    (out_result)
    );

    assign o_out_valid      = out_full;
    assign o_status         = out_result.status;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_payload_index  = out_result.payload_index;
    assign o_frame_type     = out_result.frame_type;
    assign o_serial_number  = out_result.serial_number;
    assign o_payload_length = out_result.payload_length;
    assign o_header_check   = out_result.header_check;
    assign o_payload_check  = out_result.payload_check;
    assign o_lost_frames    = out_result.lost_frames;
    assign o_good_bytes     = out_result.good_bytes;
    assign o_total_bytes    = out_result.total_bytes;

endmodule

`default_nettype wire

// File: rtl/imu_fp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  o_status,
    input  wire logic [7:0]  o_payload_byte,
    input  wire logic [7:0]  o_payload_index,
    input  wire logic [31:0] o_lost_frames,
    input  wire logic [31:0] o_total_bytes
);
    import imu_fp_pkg::*;

    logic        out_accept;
    logic        r_seen;
    logic [31:0] r_last_total;
    logic [31:0] r_last_lost;

    assign out_accept = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_accept) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_accept) begin
            r_last_total <= o_total_bytes;
            r_last_lost  <= o_lost_frames;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_total_bytes))
        else $error("stalled result changed");

    a_total_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && r_seen |-> o_total_bytes == r_last_total + 32'd1)
        else $error("total byte count skipped or repeated");

    a_lost_tracks_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && r_seen |->
            o_lost_frames == r_last_lost + {31'd0, (o_status == ST_ERROR)})
        else $error("lost frame count out of step with error status");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_PAYLOAD) |->
            (o_payload_byte == 8'd0) && (o_payload_index == 8'd0))
        else $error("payload fields nonzero outside payload status");

endmodule

bind imu_serial_frame_parser imu_fp_checker u_imu_fp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_payload_byte  (o_payload_byte),
    .o_payload_index (o_payload_index),
    .o_lost_frames   (o_lost_frames),
    .o_total_bytes   (o_total_bytes)
);

`default_nettype wire
